[design/vlfr_pkg.sv]
// Package: shared constants and types of the vision line frame receiver.
package vlfr_pkg;

  localparam logic [7:0]  HdrFirst     = 8'hAA;
  localparam logic [7:0]  HdrSecond    = 8'h55;
  localparam logic [7:0]  LenByte      = 8'd10;
  localparam logic [3:0]  PosHdr0      = 4'd0;
  localparam logic [3:0]  PosHdr1      = 4'd1;
  localparam logic [3:0]  PosLen       = 4'd2;
  localparam logic [3:0]  PosFirstData = 4'd3;
  localparam logic [3:0]  PosLastData  = 4'd12;
  localparam logic [3:0]  PosCheck     = 4'd13;
  localparam logic [7:0]  ConfCap      = 8'd100;
  localparam logic [6:0]  PixMax       = 7'd127;
  localparam logic [6:0]  OffMin       = 7'h40;   // -64
  localparam logic [6:0]  OffMax       = 7'h3F;   // 63
  localparam logic [15:0] AgeMax       = 16'hFFFF;
  localparam logic [15:0] TimeoutReset = 16'd150;
  localparam logic [6:0]  LeftReset    = 7'd56;
  localparam logic [6:0]  RightReset   = 7'd72;

  // Raw payload bytes of one collected frame, positions 3..12.
  typedef struct packed {
    logic [7:0] sequence_b;
    logic [7:0] flags_b;
    logic [7:0] off_lo;
    logic [7:0] off_hi;
    logic [7:0] edge_a;
    logic [7:0] edge_b;
    logic [7:0] seg_count;
    logic [7:0] seg_sel;
    logic [7:0] road;
    logic [7:0] conf;
  } frame_t;

  // One result beat.
  typedef struct packed {
    logic signed [6:0] line_offset;
    logic [6:0]        lo_pixel;
    logic [6:0]        hi_pixel;
    logic [7:0]        dark_width;
    logic [7:0]        seg_total;
    logic [7:0]        seg_pick;
    logic [7:0]        road_kind;
    logic [6:0]        confidence;
    logic [3:0]        status_flags;
    logic [7:0]        frame_sequence;
    logic              fresh;
    logic              new_frame;
  } result_t;

endpackage

[design/vlfr_if.sv]
// Interfaces: input, result and configuration channels of the receiver.
interface vlfr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;
  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface vlfr_out_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] line_offset;
  logic [6:0]        lo_pixel;
  logic [6:0]        hi_pixel;
  logic [7:0]        dark_width;
  logic [7:0]        seg_total;
  logic [7:0]        seg_pick;
  logic [7:0]        road_kind;
  logic [6:0]        confidence;
  logic [3:0]        status_flags;
  logic [7:0]        frame_sequence;
  logic              fresh;
  logic              new_frame;
  modport source (output valid, output line_offset, output lo_pixel, output hi_pixel,
                  output dark_width, output seg_total, output seg_pick,
                  output road_kind, output confidence, output status_flags,
                  output frame_sequence, output fresh, output new_frame, input ready);
  modport sink   (input valid, input line_offset, input lo_pixel, input hi_pixel,
                  input dark_width, input seg_total, input seg_pick,
                  input road_kind, input confidence, input status_flags,
                  input frame_sequence, input fresh, input new_frame, output ready);
endinterface

interface vlfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/vlfr_parser.sv]
// Frame parser: header hunt, length check, byte collection and running XOR.
module vlfr_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,     // byte beat leaves the input register
  input  logic [7:0]      byte_i,
  output logic            good_o,     // this byte closes a frame with good checksum
  output vlfr_pkg::frame_t frame_o
);
  import vlfr_pkg::*;

  logic [3:0] pos_q, pos_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] frame_q [PosFirstData:PosLastData];
  logic       store;

  always_comb begin
    pos_d  = pos_q;
    xor_d  = xor_q;
    store  = 1'b0;
    good_o = 1'b0;
    if (pos_q == PosHdr1) begin
      if (byte_i == HdrSecond) pos_d = PosLen;
      else if (byte_i == HdrFirst) pos_d = PosHdr1;
      else pos_d = PosHdr0;
    end else if (pos_q == PosLen) begin
      if (byte_i == LenByte) begin
        xor_d = byte_i;
        pos_d = PosFirstData;
      end else begin
        pos_d = PosHdr0;
      end
    end else if (pos_q >= PosFirstData && pos_q <= PosLastData) begin
      store = 1'b1;
      xor_d = xor_q ^ byte_i;
      pos_d = pos_q + 4'd1;
    end else if (pos_q == PosCheck) begin
      pos_d  = PosHdr0;
      good_o = (xor_q == byte_i);
    end else begin
      // hunting, also the unreachable positions above the checksum
      pos_d = (byte_i == HdrFirst) ? PosHdr1 : PosHdr0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHdr0;
      xor_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      xor_q <= xor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && store) frame_q[pos_q] <= byte_i;
  end

  assign frame_o.sequence_b = frame_q[3];
  assign frame_o.flags_b    = frame_q[4];
  assign frame_o.off_lo     = frame_q[5];
  assign frame_o.off_hi     = frame_q[6];
  assign frame_o.edge_a     = frame_q[7];
  assign frame_o.edge_b     = frame_q[8];
  assign frame_o.seg_count  = frame_q[9];
  assign frame_o.seg_sel    = frame_q[10];
  assign frame_o.road       = frame_q[11];
  assign frame_o.conf       = frame_q[12];

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PosCheck)
    else $error("parser position out of range");

endmodule

[design/vlfr_view.sv]
// Held line view: frame decode, clamping, frame-age counter and result assembly.
module vlfr_view (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             tick_i,     // beat is a millisecond tick
  input  logic             good_i,
  input  vlfr_pkg::frame_t frame_i,
  input  logic [15:0]      timeout_i,
  output vlfr_pkg::result_t res_o     // view after this beat
);
  import vlfr_pkg::*;

  logic [15:0] age_q, age_d;
  logic [6:0]  off_q, off_d, left_q, left_d, right_q, right_d, conf_q, conf_d;
  logic [7:0]  black_q, black_d, segc_q, segc_d, segs_q, segs_d;
  logic [7:0]  road_q, road_d, seq_q, seq_d;
  logic [3:0]  flags_q, flags_d;
  logic [15:0] raw;
  logic [6:0]  off_c, ea, eb, lo, hi;
  logic        fresh;

  always_comb begin
    raw = {frame_i.off_hi, frame_i.off_lo};
    if (raw[15] && !(&raw[14:6]))      off_c = OffMin;
    else if (!raw[15] && (|raw[14:6])) off_c = OffMax;
    else                               off_c = raw[6:0];
    ea = frame_i.edge_a[7] ? PixMax : frame_i.edge_a[6:0];
    eb = frame_i.edge_b[7] ? PixMax : frame_i.edge_b[6:0];
    lo = (ea > eb) ? eb : ea;
    hi = (ea > eb) ? ea : eb;
  end

  always_comb begin
    age_d   = age_q;
    off_d   = off_q;
    left_d  = left_q;
    right_d = right_q;
    black_d = black_q;
    segc_d  = segc_q;
    segs_d  = segs_q;
    road_d  = road_q;
    conf_d  = conf_q;
    flags_d = flags_q;
    seq_d   = seq_q;
    if (tick_i) begin
      if (age_q != AgeMax) age_d = age_q + 16'd1;
    end else if (good_i) begin
      age_d   = '0;
      off_d   = off_c;
      left_d  = lo;
      right_d = hi;
      black_d = frame_i.flags_b[0] ? ({1'b0, hi} - {1'b0, lo} + 8'd1) : 8'd0;
      segc_d  = frame_i.seg_count;
      segs_d  = frame_i.seg_sel;
      road_d  = frame_i.road;
      conf_d  = (frame_i.conf > ConfCap) ? ConfCap[6:0] : frame_i.conf[6:0];
      flags_d = frame_i.flags_b[3:0];
      seq_d   = frame_i.sequence_b;
    end
    fresh = (age_d <= timeout_i);

    res_o.line_offset    = off_d;
    res_o.lo_pixel       = left_d;
    res_o.hi_pixel       = right_d;
    res_o.dark_width     = black_d;
    res_o.seg_total      = segc_d;
    res_o.seg_pick       = segs_d;
    res_o.road_kind      = road_d;
    res_o.confidence     = fresh ? conf_d : 7'd0;
    res_o.status_flags   = {flags_d[3:1], flags_d[0] & fresh};
    res_o.frame_sequence = seq_d;
    res_o.fresh          = fresh;
    res_o.new_frame      = good_i & ~tick_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q   <= '0;
      off_q   <= '0;
      left_q  <= LeftReset;
      right_q <= RightReset;
      black_q <= '0;
      segc_q  <= '0;
      segs_q  <= '0;
      road_q  <= '0;
      conf_q  <= '0;
      flags_q <= '0;
      seq_q   <= '0;
    end else if (step_i) begin
      age_q   <= age_d;
      off_q   <= off_d;
      left_q  <= left_d;
      right_q <= right_d;
      black_q <= black_d;
      segc_q  <= segc_d;
      segs_q  <= segs_d;
      road_q  <= road_d;
      conf_q  <= conf_d;
      flags_q <= flags_d;
      seq_q   <= seq_d;
    end
  end

endmodule

[design/vision_line_frame_receiver.sv]
// Top level: vision line frame receiver with input and result registers.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+---------------------------------------------
//  in_i    | in  | valid/ready | mode (0 byte, 1 ms tick), rx_byte
//  out_o   | out | valid/ready | held line view, fresh, new_frame
//  cfg_i   | in  | valid/ready | data = timeout_ticks (16 bit)
//
// Two register stages: a beat is captured in the input register, then parser
// and view logic update state as the beat moves on into the result register.
// One beat per cycle is sustained, limited only by the result consumer.
// Reset clears parser position, XOR and frame age, sets the held view to its reset values; timeout is 150.
// A stalled result holds; the input register still fills, so ready drops
// only when both stages are full and the result is not taken.
// cfg_i is always ready; writes take effect on the next beat processed.
module vision_line_frame_receiver (
  input  logic   clk_i,
  input  logic   rst_ni,
  vlfr_in_if.sink    in_i,
  vlfr_out_if.source out_o,
  vlfr_cfg_if.sink   cfg_i
);
  import vlfr_pkg::*;

  logic        s1_valid_q;
  logic        s1_mode_q;
  logic [7:0]  s1_byte_q;
  logic        out_valid_q;
  result_t     out_res_q;
  logic [15:0] timeout_q;
  logic        s2_load;
  logic        good;
  frame_t      frame;
  result_t     res;

  // result register loads when it is empty or being drained
  assign s2_load     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || s2_load;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      timeout_q   <= TimeoutReset;
    end else begin
      if (in_i.ready) s1_valid_q <= in_i.valid;
      if (s2_load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
      if (cfg_i.valid) timeout_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_mode_q <= in_i.mode;
      s1_byte_q <= in_i.rx_byte;
    end
    if (s2_load) out_res_q <= res;
  end

  // parser sees only byte beats; ticks leave it untouched
  vlfr_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (s2_load && !s1_mode_q),
    .byte_i  (s1_byte_q),
    .good_o  (good),
    .frame_o (frame)
  );

  vlfr_view u_view (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s2_load),
    .tick_i    (s1_mode_q),
    .good_i    (good),
    .frame_i   (frame),
    .timeout_i (timeout_q),
    .res_o     (res)
  );

  assign out_o.valid          = out_valid_q;
  assign out_o.line_offset    = out_res_q.line_offset;
  assign out_o.lo_pixel       = out_res_q.lo_pixel;
  assign out_o.hi_pixel       = out_res_q.hi_pixel;
  assign out_o.dark_width     = out_res_q.dark_width;
  assign out_o.seg_total      = out_res_q.seg_total;
  assign out_o.seg_pick       = out_res_q.seg_pick;
  assign out_o.road_kind      = out_res_q.road_kind;
  assign out_o.confidence     = out_res_q.confidence;
  assign out_o.status_flags   = out_res_q.status_flags;
  assign out_o.frame_sequence = out_res_q.frame_sequence;
  assign out_o.fresh          = out_res_q.fresh;
  assign out_o.new_frame      = out_res_q.new_frame;

  a_new_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.new_frame |-> out_o.fresh)
    else $error("good frame reported stale");

  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.lo_pixel <= out_o.hi_pixel)
    else $error("edges out of order");

  a_stale_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.fresh |-> out_o.confidence == 7'd0 && !out_o.status_flags[0])
    else $error("stale view not cleared");

  a_conf_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.confidence <= ConfCap[6:0])
    else $error("confidence above cap");

endmodule

[bench/vision_line_frame_receiver_tb.sv]
// Testbench: feeds byte and tick beats to the line frame receiver, checks every view beat.
module vision_line_frame_receiver_tb;
  import vlfr_pkg::*;

  localparam logic ModeByte   = 1'b0;
  localparam logic ModeTick   = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } serial_item_t;

  logic clk_i;
  logic rst_ni;

  vlfr_in_if  in_bus ();
  vlfr_out_if out_bus ();
  vlfr_cfg_if cfg_bus ();

  vision_line_frame_receiver i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Beats waiting to be sent, and views expected back in order.
  serial_item_t rx_items[$];
  result_t      expected_views[$];
  serial_item_t cur_item;

  int items_queued  = 0;
  int items_checked = 0;
  int mismatches    = 0;

  // Idle control: percent chance of starting a burst, and the burst counters.
  bit quiet_run      = 1'b0;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int send_gap       = 0;
  int recv_stall     = 0;

  // Receiver model state, reset values.
  logic [15:0] timeout_cfg  = TimeoutReset;
  logic [3:0]  parse_pos    = PosHdr0;
  logic [7:0]  body_bytes [PosFirstData:PosLastData];
  logic [7:0]  sum_acc      = 8'd0;
  logic [15:0] frame_age    = 16'd0;
  logic [6:0]  held_offset  = 7'd0;
  logic [6:0]  held_left    = LeftReset;
  logic [6:0]  held_right   = RightReset;
  logic [7:0]  held_black   = 8'd0;
  logic [7:0]  held_seg_cnt = 8'd0;
  logic [7:0]  held_seg_sel = 8'd0;
  logic [7:0]  held_road    = 8'd0;
  logic [6:0]  held_conf    = 7'd0;
  logic [3:0]  held_flags   = 4'd0;
  logic [7:0]  held_seq     = 8'd0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Advances the model by one beat and returns the view it reports.
  function automatic result_t next_view(input serial_item_t item);
    result_t            view;
    logic               completed;
    logic               live;
    logic signed [15:0] off_raw;
    logic [6:0]         edge_lo;
    logic [6:0]         edge_hi;
    logic [6:0]         swap_tmp;
    completed = 1'b0;
    if (item.mode == ModeTick) begin
      if (frame_age != AgeMax) frame_age = frame_age + 16'd1;
    end else begin
      case (parse_pos)
        PosHdr1: begin
          if (item.data == HdrSecond) parse_pos = PosLen;
          else if (item.data == HdrFirst) parse_pos = PosHdr1;   // resync on repeated header
          else parse_pos = PosHdr0;
        end
        PosLen: begin
          if (item.data == LenByte) begin
            sum_acc   = item.data;
            parse_pos = PosFirstData;
          end else begin
            parse_pos = PosHdr0;   // bad length byte is not rechecked as a header
          end
        end
        PosCheck: begin
          parse_pos = PosHdr0;
          if (sum_acc == item.data) begin
            completed = 1'b1;
            off_raw   = {body_bytes[6], body_bytes[5]};
            if (off_raw < -16'sd64) held_offset = OffMin;
            else if (off_raw > 16'sd63) held_offset = OffMax;
            else held_offset = off_raw[6:0];
            edge_lo = (body_bytes[7] > {1'b0, PixMax}) ? PixMax : body_bytes[7][6:0];
            edge_hi = (body_bytes[8] > {1'b0, PixMax}) ? PixMax : body_bytes[8][6:0];
            if (edge_lo > edge_hi) begin
              swap_tmp = edge_lo;
              edge_lo  = edge_hi;
              edge_hi  = swap_tmp;
            end
            held_left    = edge_lo;
            held_right   = edge_hi;
            held_black   = body_bytes[4][0] ? ({1'b0, edge_hi} - {1'b0, edge_lo} + 8'd1) : 8'd0;
            held_seg_cnt = body_bytes[9];
            held_seg_sel = body_bytes[10];
            held_road    = body_bytes[11];
            held_conf    = (body_bytes[12] > ConfCap) ? ConfCap[6:0] : body_bytes[12][6:0];
            held_flags   = body_bytes[4][3:0];
            held_seq     = body_bytes[3];
            frame_age    = 16'd0;
          end
        end
        default: begin
          if (parse_pos >= PosFirstData && parse_pos <= PosLastData) begin
            body_bytes[parse_pos] = item.data;
            sum_acc   = sum_acc ^ item.data;
            parse_pos = parse_pos + 4'd1;
          end else begin
            parse_pos = (item.data == HdrFirst) ? PosHdr1 : PosHdr0;
          end
        end
      endcase
    end
    live = (frame_age <= timeout_cfg);
    view.line_offset    = held_offset;
    view.lo_pixel       = held_left;
    view.hi_pixel       = held_right;
    view.dark_width     = held_black;
    view.seg_total      = held_seg_cnt;
    view.seg_pick       = held_seg_sel;
    view.road_kind      = held_road;
    view.confidence     = live ? held_conf : 7'd0;
    view.status_flags   = live ? held_flags : {held_flags[3:1], 1'b0};
    view.frame_sequence = held_seq;
    view.fresh          = live;
    view.new_frame      = completed;
    return view;
  endfunction

  task automatic cmp_field(input string name, input logic signed [15:0] exp_v,
                           input logic signed [15:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  task automatic check_view(input result_t exp_v, input result_t got_v);
    cmp_field("line_offset", 16'(exp_v.line_offset), 16'(got_v.line_offset));
    cmp_field("lo_pixel", 16'(exp_v.lo_pixel), 16'(got_v.lo_pixel));
    cmp_field("hi_pixel", 16'(exp_v.hi_pixel), 16'(got_v.hi_pixel));
    cmp_field("dark_width", 16'(exp_v.dark_width), 16'(got_v.dark_width));
    cmp_field("seg_total", 16'(exp_v.seg_total), 16'(got_v.seg_total));
    cmp_field("seg_pick", 16'(exp_v.seg_pick), 16'(got_v.seg_pick));
    cmp_field("road_kind", 16'(exp_v.road_kind), 16'(got_v.road_kind));
    cmp_field("confidence", 16'(exp_v.confidence), 16'(got_v.confidence));
    cmp_field("status_flags", 16'(exp_v.status_flags), 16'(got_v.status_flags));
    cmp_field("frame_sequence", 16'(exp_v.frame_sequence), 16'(got_v.frame_sequence));
    cmp_field("fresh", 16'(exp_v.fresh), 16'(got_v.fresh));
    cmp_field("new_frame", 16'(exp_v.new_frame), 16'(got_v.new_frame));
  endtask

  function automatic int pick_pct();
    case ($urandom_range(4))
      0, 1:    return 0;
      2:       return 10;
      3:       return 30;
      default: return 60;
    endcase
  endfunction

  // Sender: presents queued beats, predicts each view as its beat is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) expected_views.push_back(next_view(cur_item));
      if (!in_bus.valid || in_bus.ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (rx_items.size() != 0) begin
          cur_item = rx_items.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.mode    <= cur_item.mode;
          in_bus.rx_byte <= cur_item.data;
          if (quiet_run) send_gap_pct = 0;
          else if ($urandom_range(63) == 0) send_gap_pct = pick_pct();
          if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
            send_gap = $urandom_range(1, 18);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each view beat against the oldest prediction.
  always @(posedge clk_i) begin
    result_t seen;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen.line_offset    = out_bus.line_offset;
        seen.lo_pixel       = out_bus.lo_pixel;
        seen.hi_pixel       = out_bus.hi_pixel;
        seen.dark_width     = out_bus.dark_width;
        seen.seg_total      = out_bus.seg_total;
        seen.seg_pick       = out_bus.seg_pick;
        seen.road_kind      = out_bus.road_kind;
        seen.confidence     = out_bus.confidence;
        seen.status_flags   = out_bus.status_flags;
        seen.frame_sequence = out_bus.frame_sequence;
        seen.fresh          = out_bus.fresh;
        seen.new_frame      = out_bus.new_frame;
        if (expected_views.size() == 0) begin
          $error("view beat arrived with none expected");
          mismatches++;
        end else begin
          check_view(expected_views.pop_front(), seen);
          items_checked++;
        end
      end
      if (quiet_run) recv_stall_pct = 0;
      else if ($urandom_range(63) == 0) recv_stall_pct = pick_pct();
      if (recv_stall != 0) begin
        recv_stall--;
        out_bus.ready <= 1'b0;
      end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
        recv_stall = $urandom_range(1, 18) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic queue_item(input logic mode, input logic [7:0] data);
    serial_item_t item;
    item.mode = mode;
    item.data = data;
    rx_items.push_back(item);
    items_queued++;
  endtask

  // Header, length, ten body bytes and checksum; ticks may be mixed in.
  task automatic push_frame(input frame_t f, input bit bad_sum, input int tick_pct);
    logic [79:0] raw;
    logic [7:0]  sum;
    logic [7:0]  b;
    raw = f;
    sum = LenByte;
    queue_item(ModeByte, HdrFirst);
    queue_item(ModeByte, HdrSecond);
    queue_item(ModeByte, LenByte);
    for (int i = 0; i < 10; i++) begin
      b   = raw[79 - 8 * i -: 8];
      sum = sum ^ b;
      if (tick_pct != 0 && $urandom_range(99) < tick_pct) queue_item(ModeTick, 8'($urandom));
      queue_item(ModeByte, b);
    end
    if (bad_sum) sum = sum ^ 8'(1 << $urandom_range(7));
    queue_item(ModeByte, sum);
  endtask

  function automatic frame_t rand_frame();
    frame_t      f;
    logic [15:0] off;
    case ($urandom_range(2))
      0: off = 16'($urandom);
      1: off = 16'($urandom_range(140)) - 16'd70;
      default: begin
        case ($urandom_range(5))
          0:       off = 16'h8000;
          1:       off = 16'h7FFF;
          2:       off = 16'hFFC0;
          3:       off = 16'h003F;
          4:       off = 16'hFFBF;
          default: off = 16'h0040;
        endcase
      end
    endcase
    f.sequence_b = 8'($urandom);
    f.flags_b    = 8'($urandom);
    f.off_lo     = off[7:0];
    f.off_hi     = off[15:8];
    f.edge_a     = 8'($urandom);
    f.edge_b     = 8'($urandom);
    f.seg_count  = 8'($urandom);
    f.seg_sel    = 8'($urandom);
    f.road       = 8'($urandom);
    f.conf       = 8'($urandom);
    return f;
  endfunction

  // Mostly well formed frames, with bad sums, bad lengths, cut frames, noise and ticks.
  task automatic fill_random(input int budget);
    int         start;
    int         r;
    int         k;
    logic [7:0] len;
    start = items_queued;
    while (items_queued - start < budget) begin
      r = $urandom_range(99);
      if (r < 50) begin
        push_frame(rand_frame(), 1'b0, 0);
      end else if (r < 58) begin
        queue_item(ModeByte, HdrFirst);
        push_frame(rand_frame(), 1'b0, 0);
      end else if (r < 66) begin
        push_frame(rand_frame(), 1'b0, 15);
      end else if (r < 72) begin
        push_frame(rand_frame(), 1'b1, 0);
      end else if (r < 77) begin
        len = 8'($urandom);
        if (len == LenByte) len = LenByte + 8'd1;
        queue_item(ModeByte, HdrFirst);
        queue_item(ModeByte, HdrSecond);
        queue_item(ModeByte, len);
      end else if (r < 87) begin
        // Long bursts cross the timeout when it is small enough to reach.
        if ($urandom_range(3) == 0 && timeout_cfg < 16'd200)
          k = int'(timeout_cfg) + $urandom_range(1, 4);
        else
          k = $urandom_range(1, 6);
        repeat (k) queue_item(ModeTick, 8'($urandom));
      end else if (r < 94) begin
        repeat ($urandom_range(1, 5)) queue_item(ModeByte, 8'($urandom));
      end else begin
        queue_item(ModeByte, HdrFirst);
        queue_item(ModeByte, HdrSecond);
        queue_item(ModeByte, LenByte);
        repeat ($urandom_range(1, 9)) queue_item(ModeByte, 8'($urandom));
      end
    end
  endtask

  task automatic write_timeout(input logic [15:0] value);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    timeout_cfg = value;
    cfg_bus.valid <= 1'b0;
  endtask

  // Waits until the view of every queued beat has come back and been checked.
  task automatic drain();
    while (items_checked != items_queued) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    frame_t f;
    rst_ni          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.mode     = ModeByte;
    in_bus.rx_byte  = 8'd0;
    out_bus.ready   = 1'b0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.data    = 16'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset view, resync on a doubled header into a frame of extreme
    // values, then a header whose length byte is itself a header byte.
    queue_item(ModeTick, 8'hFF);
    f.sequence_b = 8'hFF;
    f.flags_b    = 8'hFF;
    f.off_lo     = 8'h00;
    f.off_hi     = 8'h80;
    f.edge_a     = 8'hFF;
    f.edge_b     = 8'h00;
    f.seg_count  = 8'hFF;
    f.seg_sel    = 8'h00;
    f.road       = 8'hFF;
    f.conf       = 8'hFF;
    queue_item(ModeByte, HdrFirst);
    push_frame(f, 1'b0, 0);
    queue_item(ModeByte, HdrFirst);
    queue_item(ModeByte, HdrSecond);
    queue_item(ModeByte, HdrFirst);
    queue_item(ModeByte, HdrSecond);
    queue_item(ModeByte, LenByte);
    queue_item(ModeTick, 8'h00);
    drain();

    write_timeout(16'd0);
    fill_random(230);
    drain();
    write_timeout(16'hFFFF);
    fill_random(230);
    drain();
    write_timeout(16'($urandom_range(1, 40)));
    fill_random(230);
    drain();

    // Last stretch runs without idle cycles on either side.
    quiet_run = 1'b1;
    write_timeout(TimeoutReset);
    fill_random(260);
    drain();

    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("vision_line_frame_receiver_tb: clean");
    end else begin
      $display("vision_line_frame_receiver_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("vision_line_frame_receiver_tb: errors");
    $finish;
  end

endmodule
